>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define MSPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge, off during reset
`define MSPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mspi_pkg.sv
// shared types, constants and the saturation helper for the speed controller
`timescale 1ns / 1ps

package mspi_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_PROP_GAIN        = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN       = 3'd1;
    localparam logic [2:0] REG_SPEED_NORMAL     = 3'd2;
    localparam logic [2:0] REG_SPEED_ROUNDABOUT = 3'd3;
    localparam logic [2:0] REG_SPEED_REDUCED    = 3'd4;
    localparam logic [2:0] REG_DRIVE_LIMIT      = 3'd5;
    localparam logic [2:0] REG_COUNT_TO_SPEED   = 3'd6;

    // register reset values
    localparam logic [23:0] PROP_GAIN_RST        = 24'd2097152;
    localparam logic [23:0] INTEG_GAIN_RST       = 24'd1114112;
    localparam logic [19:0] SPEED_NORMAL_RST     = 20'd98304;
    localparam logic [19:0] SPEED_ROUNDABOUT_RST = 20'd72090;
    localparam logic [19:0] SPEED_REDUCED_RST    = 20'd65536;
    localparam logic [22:0] DRIVE_LIMIT_RST      = 23'd4587520;
    localparam logic [15:0] COUNT_TO_SPEED_RST   = 16'd637;

    // road and counter constants
    localparam logic [7:0]         ROAD_STRAIGHT = 8'd0;
    localparam logic [11:0]        SENSOR_LOW    = 12'd100;
    localparam logic [11:0]        SENSOR_HIGH   = 12'd140;
    localparam logic signed [16:0] TOTAL_WRAP    = 17'sd32600;
    localparam logic signed [16:0] TOTAL_FLOOR   = -17'sd32768;
    localparam logic [11:0]        TICK_LIMIT    = 12'd3000;

    // serial multiplier: one multiplier bit per cycle
    localparam int MAC_STEPS = 24;
    localparam int MAC_CNT_W = $clog2(MAC_STEPS);
    localparam int MAC_RES_W = 33 + MAC_STEPS;

    // operands and result of the serial multiply-accumulate
    typedef struct packed {
        logic                 start;
        logic signed [31:0]   a1;
        logic signed [31:0]   a2;
        logic [MAC_STEPS-1:0] b1;
        logic [MAC_STEPS-1:0] b2;
    } mspi_mac_req_t;

    typedef struct packed {
        logic                         done;
        logic signed [MAC_RES_W-1:0]  result;
    } mspi_mac_rsp_t;

    // saturate a 41-bit signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if ((v[40:31] == 10'h000) || (v[40:31] == 10'h3FF))
        begin
            r = v[31:0];
        end
        else if (v[40])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

>>> sv/mspi_serial_mac.sv
// bit-serial multiply-accumulate: a1*b1 + a2*b2, one multiplier bit per cycle
`timescale 1ns / 1ps

module mspi_serial_mac
    import mspi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  mspi_mac_req_t req,
    output mspi_mac_rsp_t rsp
);

    logic signed [32:0]    acc_reg, acc_next;
    logic [MAC_STEPS-1:0]  low_reg, low_next;
    logic [MAC_STEPS-1:0]  b1_reg, b1_next;
    logic [MAC_STEPS-1:0]  b2_reg, b2_next;
    logic signed [31:0]    a1_reg, a1_next;
    logic signed [31:0]    a2_reg, a2_next;
    logic [MAC_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic signed [32:0]    part;
    logic signed [33:0]    sum;

    // partial products of the current multiplier bits, added at the top
    always_comb
    begin
        part = (b1_reg[0] ? 33'(a1_reg) : 33'sd0) + (b2_reg[0] ? 33'(a2_reg) : 33'sd0);
        sum  = 34'(acc_reg) + 34'(part);
    end

    // next values of the shift-add datapath
    always_comb
    begin
        acc_next  = acc_reg;
        low_next  = low_reg;
        b1_next   = b1_reg;
        b2_next   = b2_reg;
        a1_next   = a1_reg;
        a2_next   = a2_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            low_next  = '0;
            b1_next   = req.b1;
            b2_next   = req.b2;
            a1_next   = req.a1;
            a2_next   = req.a2;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum[33:1];
            low_next = {sum[0], low_reg[MAC_STEPS-1:1]};
            b1_next  = b1_reg >> 1;
            b2_next  = b2_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MAC_CNT_W'(MAC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        low_reg <= low_next;
        b1_reg  <= b1_next;
        b2_reg  <= b2_next;
        a1_reg  <= a1_next;
        a2_reg  <= a2_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = {acc_reg, low_reg};

endmodule

>>> sv/motor_speed_incremental_pi_core.sv
// incremental pi speed controller: target choice, serial pi step, duties and counters
//
//  channel   signals                                    direction
//  input     in_valid/in_ready + 5 field ports           into block
//  output    out_valid/out_ready + 6 field ports         out of block
//  config    psel/penable/pwrite/paddr/pwdata/prdata     apb, pready tied high
//
//  an accepted word steps through speed, err, diff, pi, sum, clamp and out;
//  speed and pi each wait on a pass through the bit-serial mac
//  (measured speed, then the pi sum)
//  rst_n clears the pi state, counters, held duties and loads register defaults
//  a finished result waits in the output register; the next word is taken
//  meanwhile, and the last step stalls only if the output is still full
`timescale 1ns / 1ps

module motor_speed_incremental_pi_core
    import mspi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input words
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] encoder_delta,
    input  logic               run_enable,
    input  logic [7:0]         road_type,
    input  logic [11:0]        center_sensor,
    input  logic               in_roundabout,
    // result words
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        forward_duty,
    output logic [15:0]        reverse_duty,
    output logic               duty_valid,
    output logic signed [23:0] drive_value,
    output logic signed [15:0] encoder_total,
    output logic [11:0]        run_ticks,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPEED,
        S_ERR,
        S_DIFF,
        S_PI,
        S_SUM,
        S_CLAMP,
        S_OUT
    } state_t;

    // configuration registers
    logic [23:0] prop_gain_reg;
    logic [23:0] integ_gain_reg;
    logic [19:0] speed_normal_reg;
    logic [19:0] speed_roundabout_reg;
    logic [19:0] speed_reduced_reg;
    logic [22:0] drive_limit_reg;
    logic [15:0] count_to_speed_reg;

    // control and persistent state
    state_t             state_reg, state_next;
    logic               mac_start_reg, mac_start_next;
    logic signed [23:0] level_reg, level_next;
    logic signed [31:0] prev_err_reg, prev_err_next;
    logic signed [15:0] total_reg, total_next;
    logic [11:0]        tick_reg, tick_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        fwd_reg, fwd_next;
    logic [15:0]        rev_reg, rev_next;
    logic               duty_valid_reg, duty_valid_next;
    logic signed [23:0] drive_out_reg, drive_out_next;
    logic signed [15:0] total_out_reg, total_out_next;
    logic [11:0]        ticks_out_reg, ticks_out_next;

    // per-word working registers
    logic signed [15:0] delta_reg, delta_next;
    logic [19:0]        target_reg, target_next;
    logic signed [31:0] speed_reg, speed_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] diff_reg, diff_next;
    logic signed [31:0] add_reg, add_next;
    logic signed [31:0] sum_reg, sum_next;

    mspi_mac_req_t mac_req;
    mspi_mac_rsp_t mac_rsp;

    logic               cfg_write;
    logic               in_take;
    logic               normal_road;
    logic               count_tick;
    logic [19:0]        target_sel;
    logic signed [16:0] total_sum;
    logic signed [32:0] lim_pos;
    logic signed [32:0] lim_neg;
    logic signed [23:0] level_mag;
    logic [29:0]        duty_scaled;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_take   = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg        <= PROP_GAIN_RST;
            integ_gain_reg       <= INTEG_GAIN_RST;
            speed_normal_reg     <= SPEED_NORMAL_RST;
            speed_roundabout_reg <= SPEED_ROUNDABOUT_RST;
            speed_reduced_reg    <= SPEED_REDUCED_RST;
            drive_limit_reg      <= DRIVE_LIMIT_RST;
            count_to_speed_reg   <= COUNT_TO_SPEED_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_PROP_GAIN:        prop_gain_reg        <= pwdata[23:0];
                REG_INTEG_GAIN:       integ_gain_reg       <= pwdata[23:0];
                REG_SPEED_NORMAL:     speed_normal_reg     <= pwdata[19:0];
                REG_SPEED_ROUNDABOUT: speed_roundabout_reg <= pwdata[19:0];
                REG_SPEED_REDUCED:    speed_reduced_reg    <= pwdata[19:0];
                REG_DRIVE_LIMIT:      drive_limit_reg      <= pwdata[22:0];
                REG_COUNT_TO_SPEED:   count_to_speed_reg   <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        case (paddr[4:2])
            REG_PROP_GAIN:        prdata = 32'(prop_gain_reg);
            REG_INTEG_GAIN:       prdata = 32'(integ_gain_reg);
            REG_SPEED_NORMAL:     prdata = 32'(speed_normal_reg);
            REG_SPEED_ROUNDABOUT: prdata = 32'(speed_roundabout_reg);
            REG_SPEED_REDUCED:    prdata = 32'(speed_reduced_reg);
            REG_DRIVE_LIMIT:      prdata = 32'(drive_limit_reg);
            REG_COUNT_TO_SPEED:   prdata = 32'(count_to_speed_reg);
            default:              prdata = '0;
        endcase
    end

    // target choice and run-tick condition from the incoming word
    always_comb
    begin
        normal_road = (road_type == ROAD_STRAIGHT) && (center_sensor > SENSOR_LOW)
                      && (center_sensor < SENSOR_HIGH) && !in_roundabout;
        count_tick  = run_enable && (normal_road || !in_roundabout);
        if (!run_enable)
        begin
            target_sel = '0;
        end
        else if (normal_road)
        begin
            target_sel = speed_normal_reg;
        end
        else if (in_roundabout)
        begin
            target_sel = speed_roundabout_reg;
        end
        else
        begin
            target_sel = speed_reduced_reg;
        end
    end

    // encoder total: zeroed past the wrap limit, floored at the bottom
    assign total_sum = 17'(total_reg) + 17'(encoder_delta);

    // mac operands: speed pass, then the two pi products
    always_comb
    begin
        mac_req.start = mac_start_reg;
        if (state_reg == S_PI)
        begin
            mac_req.a1 = diff_reg;
            mac_req.b1 = prop_gain_reg;
            mac_req.a2 = err_reg;
            mac_req.b2 = integ_gain_reg;
        end
        else
        begin
            mac_req.a1 = 32'(delta_reg);
            mac_req.b1 = MAC_STEPS'(count_to_speed_reg);
            mac_req.a2 = '0;
            mac_req.b2 = '0;
        end
    end

    mspi_serial_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .rsp   (mac_rsp)
    );

    // clamp bounds and duty scaling (x100 = x64 + x32 + x4)
    always_comb
    begin
        lim_pos     = $signed({10'd0, drive_limit_reg});
        lim_neg     = -lim_pos;
        level_mag   = level_reg[23] ? -level_reg : level_reg;
        duty_scaled = (30'(level_mag[22:0]) << 6) + (30'(level_mag[22:0]) << 5)
                      + (30'(level_mag[22:0]) << 2);
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        mac_start_next  = 1'b0;
        level_next      = level_reg;
        prev_err_next   = prev_err_reg;
        total_next      = total_reg;
        tick_next       = tick_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        fwd_next        = fwd_reg;
        rev_next        = rev_reg;
        duty_valid_next = duty_valid_reg;
        drive_out_next  = drive_out_reg;
        total_out_next  = total_out_reg;
        ticks_out_next  = ticks_out_reg;
        delta_next      = delta_reg;
        target_next     = target_reg;
        speed_next      = speed_reg;
        err_next        = err_reg;
        diff_next       = diff_reg;
        add_next        = add_reg;
        sum_next        = sum_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    delta_next     = encoder_delta;
                    target_next    = target_sel;
                    mac_start_next = 1'b1;
                    state_next     = S_SPEED;
                    if (count_tick && (tick_reg < TICK_LIMIT))
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                    if (total_sum > TOTAL_WRAP)
                    begin
                        total_next = '0;
                    end
                    else if (total_sum < TOTAL_FLOOR)
                    begin
                        total_next = TOTAL_FLOOR[15:0];
                    end
                    else
                    begin
                        total_next = total_sum[15:0];
                    end
                end
            end
            S_SPEED:
            begin
                if (mac_rsp.done)
                begin
                    speed_next = mac_rsp.result[31:0];
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                err_next   = sat32(41'(34'($signed({14'd0, target_reg})) - 34'(speed_reg)));
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                diff_next      = sat32(41'(34'(err_reg) - 34'(prev_err_reg)));
                prev_err_next  = err_reg;
                mac_start_next = 1'b1;
                state_next     = S_PI;
            end
            S_PI:
            begin
                // floor of the sum over 2^16 is an arithmetic shift
                if (mac_rsp.done)
                begin
                    add_next   = sat32(mac_rsp.result[MAC_RES_W-1:16]);
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                sum_next   = sat32(41'(34'(level_reg) + 34'(add_reg)));
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (33'(sum_reg) >= lim_pos)
                begin
                    level_next = lim_pos[23:0];
                end
                else if (33'(sum_reg) <= lim_neg)
                begin
                    level_next = lim_neg[23:0];
                end
                else
                begin
                    level_next = sum_reg[23:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // duties are held when the level sits at zero
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    duty_valid_next = (level_reg != '0);
                    drive_out_next  = level_reg;
                    total_out_next  = total_reg;
                    ticks_out_next  = tick_reg;
                    if (level_reg > 24'sd0)
                    begin
                        fwd_next = 16'(duty_scaled[29:16]);
                        rev_next = '0;
                    end
                    else if (level_reg < 24'sd0)
                    begin
                        fwd_next = '0;
                        rev_next = 16'(duty_scaled[29:16]);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mac_start_reg  <= 1'b0;
            level_reg      <= '0;
            prev_err_reg   <= '0;
            total_reg      <= '0;
            tick_reg       <= '0;
            out_valid_reg  <= 1'b0;
            fwd_reg        <= '0;
            rev_reg        <= '0;
            duty_valid_reg <= 1'b0;
            drive_out_reg  <= '0;
            total_out_reg  <= '0;
            ticks_out_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mac_start_reg  <= mac_start_next;
            level_reg      <= level_next;
            prev_err_reg   <= prev_err_next;
            total_reg      <= total_next;
            tick_reg       <= tick_next;
            out_valid_reg  <= out_valid_next;
            fwd_reg        <= fwd_next;
            rev_reg        <= rev_next;
            duty_valid_reg <= duty_valid_next;
            drive_out_reg  <= drive_out_next;
            total_out_reg  <= total_out_next;
            ticks_out_reg  <= ticks_out_next;
        end
    end

    // per-word working registers
    always_ff @(posedge clk)
    begin
        delta_reg  <= delta_next;
        target_reg <= target_next;
        speed_reg  <= speed_next;
        err_reg    <= err_next;
        diff_reg   <= diff_next;
        add_reg    <= add_next;
        sum_reg    <= sum_next;
    end

    assign out_valid     = out_valid_reg;
    assign forward_duty  = fwd_reg;
    assign reverse_duty  = rev_reg;
    assign duty_valid    = duty_valid_reg;
    assign drive_value   = drive_out_reg;
    assign encoder_total = total_out_reg;
    assign run_ticks     = ticks_out_reg;

endmodule

>>> sv/mspi_checker.sv
// port-level checks for the speed controller and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mspi_checker
    import mspi_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [15:0]        forward_duty,
    input logic [15:0]        reverse_duty,
    input logic               duty_valid,
    input logic signed [23:0] drive_value,
    input logic signed [15:0] encoder_total,
    input logic [11:0]        run_ticks
);

    // one word at a time: no acceptance right after one
    `MSPI_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready, "word taken while busy")

    // a stalled result keeps its level
    `MSPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_value), "stalled result changed")

    // a negative level never drives forward
    `MSPI_ASSERT_SAME(a_dir, out_valid && duty_valid && drive_value[23], forward_duty == 16'd0, "forward duty on negative level")

    // run-tick counter never passes its limit
    `MSPI_ASSERT_SAME(a_ticks, out_valid, run_ticks <= TICK_LIMIT, "run ticks past limit")

    // encoder total never exceeds the wrap limit
    `MSPI_ASSERT_SAME(a_total, out_valid, 17'(encoder_total) <= TOTAL_WRAP, "encoder total past wrap limit")

endmodule

bind motor_speed_incremental_pi_core mspi_checker u_mspi_checker (.*);
